// File: rtl/hpa_pkg.sv
// shared constants and types for the hls pixel adjuster
`default_nettype none

package hpa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CH_W          = 8;
  localparam int SHIFT_W       = 18;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 18;
  localparam int NUM_SHIFTS    = 3;
  // widest divisor: six times the channel spread
  localparam int DIV_DEN_W     = 11;
  // lightness divisor, twice full scale
  localparam int L_DEN         = 510;
  // register stages of the back conversion
  localparam int BACK_LAT      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_SHIFT   = 2'd0,
    CFG_SAT_SHIFT   = 2'd1,
    CFG_LIGHT_SHIFT = 2'd2,
    CFG_KEEP_LUM    = 2'd3
  } cfg_reg_e;

  // hue sextants, named by the channel that is rising or falling
  localparam logic [2:0] SEXT_GREEN_RISE = 3'd0;
  localparam logic [2:0] SEXT_RED_FALL   = 3'd1;
  localparam logic [2:0] SEXT_BLUE_RISE  = 3'd2;
  localparam logic [2:0] SEXT_GREEN_FALL = 3'd3;
  localparam logic [2:0] SEXT_RED_RISE   = 3'd4;

endpackage

`default_nettype wire

// File: rtl/hls_pixel_adjust.sv
// top level of the hls pixel adjuster
//
// one rgba pixel per input transaction, one adjusted pixel per output
// transaction, both on valid/stall channels
// config: write cfg_we_i with cfg_idx_i (hue, saturation, lightness shift,
//   keep luminance) and cfg_wdata_i, only while the pipeline is empty
// stages: the input registers, the divider stages, which resolve one
//   quotient bit per stage, the adjust register and the back conversion
// throughput: one pixel per clock cycle while the output is not stalled
// the pipeline moves as one; a stall on the output freezes every stage
//   once the output register holds a pixel, and the input stalls with it
// reset clears the valid bits and the shift registers; pixels in flight
//   are dropped
// alpha rides along the pipeline untouched
`default_nettype none

module hls_pixel_adjust import hpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // pixel in
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CH_W-1:0]       red_in_i,
  input  wire logic [CH_W-1:0]       green_in_i,
  input  wire logic [CH_W-1:0]       blue_in_i,
  input  wire logic [CH_W-1:0]       alpha_in_i,
  // pixel out
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [CH_W-1:0]       red_out_o,
  output logic      [CH_W-1:0]       green_out_o,
  output logic      [CH_W-1:0]       blue_out_o,
  output logic      [CH_W-1:0]       alpha_out_o,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int F     = FRAC_BITS;
  localparam int QW    = F + 1;              // quotient width, values up to one
  localparam int NW    = DIV_DEN_W + QW - 1; // dividend width
  localparam int SW    = F + 2;              // scaled shift width, signed
  localparam int NST   = QW + 2 + BACK_LAT;  // pipeline stages in total
  localparam int ADJ   = QW + 1;             // stage index of the adjust register
  localparam logic [F:0] ONE_V = (F+1)'(1) << F;
  // lightness dividend after halving, and the reciprocal of 255
  localparam int LM_W  = F + 8;
  localparam logic [F+8:0] L_RCP = (F+9)'(((64'd1 << (F + 16)) + 64'd254) / 64'd255);

  // config registers
  logic [SHIFT_W-1:0] cfg_shift_q [NUM_SHIFTS];
  logic               keep_lum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_SHIFTS; j++) cfg_shift_q[j] <= '0;
      keep_lum_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_HUE_SHIFT:   cfg_shift_q[0] <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_SAT_SHIFT:   cfg_shift_q[1] <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_LIGHT_SHIFT: cfg_shift_q[2] <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_KEEP_LUM:    keep_lum_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // shifts rescaled from q1.16 to FRAC_BITS, truncating toward zero
  logic signed [SW-1:0] shift_sc [NUM_SHIFTS];

  for (genvar j = 0; j < NUM_SHIFTS; j++) begin : g_scale
    if (F >= 16) begin : g_up
      assign shift_sc[j] = SW'($signed(cfg_shift_q[j])) <<< (F - 16);
    end else begin : g_down
      logic [SHIFT_W-1:0] mag, mag_sh;
      always_comb begin
        mag    = cfg_shift_q[j][SHIFT_W-1] ? SHIFT_W'(-cfg_shift_q[j]) : cfg_shift_q[j];
        mag_sh = mag >> (16 - F);
      end
      assign shift_sc[j] = cfg_shift_q[j][SHIFT_W-1] ? -$signed(SW'(mag_sh))
                                                     : $signed(SW'(mag_sh));
    end
  end

  // pipeline control: everything advances unless the output is held
  logic [NST-1:0]  vld_q;
  logic [CH_W-1:0] alpha_q [NST];
  logic [QW:0]     nz_q;
  logic            adv;

  assign adv         = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NST-1];
  assign alpha_out_o = alpha_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q[0] <= alpha_in_i;
      for (int k = 1; k < NST; k++) alpha_q[k] <= alpha_q[k-1];
    end
  end

  // stage 0: max, min, hue numerator and the dividends
  logic [CH_W-1:0]      v, m, d;
  logic [CH_W:0]        vm, den9;
  logic [DIV_DEN_W-1:0] d11, n;
  logic                 nz_d;
  logic [NW-1:0]        num_s_q, num_h_q;
  logic [LM_W-1:0]      lnum_q;
  logic [DIV_DEN_W-1:0] den_s_q, den_h_q;

  always_comb begin
    v    = (red_in_i > green_in_i) ? red_in_i : green_in_i;
    v    = (v > blue_in_i) ? v : blue_in_i;
    m    = (red_in_i < green_in_i) ? red_in_i : green_in_i;
    m    = (m < blue_in_i) ? m : blue_in_i;
    d    = v - m;
    vm   = {1'b0, v} + {1'b0, m};
    den9 = (vm <= (CH_W+1)'(255)) ? vm : (CH_W+1)'(L_DEN) - vm;
    d11  = DIV_DEN_W'(d);
    // hue numerator over six times the spread, by sextant
    if (red_in_i == v) begin
      n = (green_in_i == m) ? DIV_DEN_W'(5 * d11 + DIV_DEN_W'(v - blue_in_i))
                            : d11 - DIV_DEN_W'(v - green_in_i);
    end else if (green_in_i == v) begin
      n = (blue_in_i == m) ? d11 + DIV_DEN_W'(v - red_in_i)
                           : DIV_DEN_W'(3 * d11 - DIV_DEN_W'(v - blue_in_i));
    end else begin
      n = (red_in_i == m) ? DIV_DEN_W'(3 * d11 + DIV_DEN_W'(v - green_in_i))
                          : DIV_DEN_W'(5 * d11 - DIV_DEN_W'(v - red_in_i));
    end
    nz_d = (vm != '0) && (d != '0);
  end

  // rounding terms are all below one, so they just fill the fraction bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lnum_q  <= {vm, (F-1)'(127)};
      num_s_q <= {3'b000, d, F'(den9 >> 1)};
      num_h_q <= {n, F'(3 * d11)};
      den_s_q <= DIV_DEN_W'(den9);
      den_h_q <= DIV_DEN_W'(6 * d11);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
    end else if (adv) begin
      nz_q <= {nz_q[QW-1:0], nz_d};
    end
  end

  // lightness: the sum over 510, halved and then times the reciprocal of 255,
  // exact over the whole dividend range; delayed to line up with the dividers
  logic [2*F+16:0] lprod_q;
  logic [F:0]      lq_q [QW-1];
  logic [QW-1:0]   quo_l, quo_s, quo_h;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lprod_q <= lnum_q * L_RCP;
      lq_q[0] <= lprod_q[2*F+16:F+16];
      for (int k = 1; k < QW - 1; k++) lq_q[k] <= lq_q[k-1];
    end
  end

  assign quo_l = lq_q[QW-2];

  // stages 1..QW: saturation and hue dividers side by side

  hpa_div #(.QUO_W(QW), .DEN_W(DIV_DEN_W), .NUM_W(NW)) u_div_s (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_s_q),
    .den_i (den_s_q),
    .quo_o (quo_s)
  );

  hpa_div #(.QUO_W(QW), .DEN_W(DIV_DEN_W), .NUM_W(NW)) u_div_h (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_h_q),
    .den_i (den_h_q),
    .quo_o (quo_h)
  );

  // adjust stage: hue wraps modulo one turn, the others clamp to zero..one
  function automatic logic [F:0] clamp01(input logic signed [SW:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > $signed({2'b00, ONE_V})) begin
      return ONE_V;
    end
    return x[F:0];
  endfunction

  logic               nz_adj;
  logic [QW-1:0]      hh0, ss0;
  logic signed [SW:0] hsum, ssum, lsum;
  logic [F-1:0]       hh_q;
  logic [F:0]         ss_q, ll_q;

  always_comb begin
    // grey or black: no hue, no saturation
    nz_adj = nz_q[QW];
    hh0    = nz_adj ? quo_h : '0;
    ss0    = nz_adj ? quo_s : '0;
    hsum   = $signed({2'b00, hh0}) + (SW+1)'(shift_sc[0]);
    ssum   = $signed({2'b00, ss0}) + (SW+1)'(shift_sc[1]);
    lsum   = $signed({2'b00, quo_l}) + (SW+1)'(shift_sc[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh_q <= hsum[F-1:0];
      ss_q <= clamp01(ssum);
      ll_q <= keep_lum_q ? quo_l : clamp01(lsum);
    end
  end

  // back conversion, BACK_LAT stages ending in the output register
  hpa_hls2rgb #(.FRAC_BITS(F)) u_hls2rgb (
    .clk_i   (clk_i),
    .en_i    (adv),
    .ll_i    (ll_q),
    .ss_i    (ss_q),
    .hh_i    (hh_q),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

  // input stalls only behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  // a frozen pipeline keeps its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved while frozen");

  // adjusted saturation and lightness stay within zero..one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ADJ] |-> (ll_q <= ONE_V && ss_q <= ONE_V))
    else $error("adjusted level out of range");

  // grey marker moves in step with the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !vld_q[0]) |=> !nz_q[1] || $past(nz_q[0]))
    else $error("grey marker out of step");

endmodule

`default_nettype wire

// File: rtl/hpa_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module hpa_div import hpa_pkg::*; #(
  parameter int QUO_W = FRAC_BITS_DEF + 1,
  parameter int DEN_W = DIV_DEN_W,
  parameter int NUM_W = DEN_W + QUO_W - 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BitIdx = QUO_W - 1 - s;
    logic [NUM_W-1:0] rem_in, trial, rem_d;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in, quo_d;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      trial = NUM_W'(den_in) << BitIdx;
      ge    = (rem_in >= trial);
      rem_d = ge ? (rem_in - trial) : rem_in;
      quo_d = quo_in;
      quo_d[BitIdx] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/hpa_hls2rgb.sv
// four-stage hls to rgb back conversion
`default_nettype none

module hpa_hls2rgb import hpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FRAC_BITS:0]   ll_i,
  input  wire logic [FRAC_BITS:0]   ss_i,
  input  wire logic [FRAC_BITS-1:0] hh_i,
  output logic      [CH_W-1:0]      red_o,
  output logic      [CH_W-1:0]      green_o,
  output logic      [CH_W-1:0]      blue_o
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0]     ONE_V  = (F+1)'(1) << F;
  localparam logic [F:0]     HALF_V = (F+1)'(1) << (F-1);
  localparam logic [2*F+1:0] HALF_P = (2*F+2)'(1) << (F-1);
  localparam logic [2*F:0]   HALF_Q = (2*F+1)'(1) << (F-1);

  function automatic logic [CH_W-1:0] to8(input logic [F:0] x);
    logic [CH_W:0] y;
    y = x[F:F-CH_W];
    return y[CH_W] ? {CH_W{1'b1}} : y[CH_W-1:0];
  endfunction

  // stage 1: lightness times saturation, six times hue
  logic [2*F+1:0] prod_q;
  logic [F+2:0]   h6_q;
  logic [F:0]     ll1_q, ss1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ll_i * ss_i;
      h6_q   <= {1'b0, hh_i, 2'b00} + {2'b00, hh_i, 1'b0};
      ll1_q  <= ll_i;
      ss1_q  <= ss_i;
    end
  end

  // stage 2: top and bottom levels
  logic [2*F+1:0]     prod_r;
  logic [F:0]         mls;
  logic signed [F+2:0] top_s, bot_s;
  logic [F:0]         top_d, bot_d;
  logic [F:0]         top2_q, bot2_q;
  logic [2:0]         sext2_q;
  logic [F-1:0]       frac2_q;

  always_comb begin
    prod_r = prod_q + HALF_P;
    mls    = prod_r[2*F:F];
    if (ll1_q <= HALF_V) begin
      top_s = $signed({2'b00, ll1_q}) + $signed({2'b00, mls});
    end else begin
      top_s = $signed({2'b00, ll1_q}) + $signed({2'b00, ss1_q}) - $signed({2'b00, mls});
    end
    if (top_s < 0) begin
      top_d = '0;
    end else if (top_s > $signed({2'b00, ONE_V})) begin
      top_d = ONE_V;
    end else begin
      top_d = top_s[F:0];
    end
    bot_s = $signed({1'b0, ll1_q, 1'b0}) - $signed({2'b00, top_d});
    if (bot_s < 0) begin
      bot_d = '0;
    end else if (bot_s > $signed({2'b00, top_d})) begin
      bot_d = top_d;
    end else begin
      bot_d = bot_s[F:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top2_q  <= top_d;
      bot2_q  <= bot_d;
      sext2_q <= h6_q[F+2:F];
      frac2_q <= h6_q[F-1:0];
    end
  end

  // stage 3: span times sextant fraction
  logic [2*F:0] qp_q;
  logic [F:0]   top3_q, bot3_q;
  logic [2:0]   sext3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qp_q    <= (top2_q - bot2_q) * frac2_q;
      top3_q  <= top2_q;
      bot3_q  <= bot2_q;
      sext3_q <= sext2_q;
    end
  end

  // stage 4: pick channels by sextant
  logic [2*F:0] qp_r;
  logic [F:0]   q, rise, fall;
  logic [F:0]   r_d, g_d, b_d;

  always_comb begin
    qp_r = qp_q + HALF_Q;
    q    = qp_r[2*F:F];
    rise = bot3_q + q;
    fall = top3_q - q;
    case (sext3_q)
      SEXT_GREEN_RISE: begin r_d = top3_q; g_d = rise;   b_d = bot3_q; end
      SEXT_RED_FALL:   begin r_d = fall;   g_d = top3_q; b_d = bot3_q; end
      SEXT_BLUE_RISE:  begin r_d = bot3_q; g_d = top3_q; b_d = rise;   end
      SEXT_GREEN_FALL: begin r_d = bot3_q; g_d = fall;   b_d = top3_q; end
      SEXT_RED_RISE:   begin r_d = rise;   g_d = bot3_q; b_d = top3_q; end
      default:         begin r_d = top3_q; g_d = bot3_q; b_d = fall;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_o   <= to8(r_d);
      green_o <= to8(g_d);
      blue_o  <= to8(b_d);
    end
  end

endmodule

`default_nettype wire
